@@ rtl/sprq_pkg.sv @@
// ----------------------------------------------------------------------------
// sprq_pkg
// Request codes, status codes and the compare result shared by the sorted
// request priority queue modules.
// ----------------------------------------------------------------------------
package sprq_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REPLACE = 2'd1,
        REQ_POP_MIN = 2'd2,
        REQ_REMOVE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Result of one (timestamp, pid) compare: entry against key.
    typedef struct packed {
        logic after;   // entry sorts strictly after the key
        logic equal;   // entry matches the key exactly
    } t_cmp;

endpackage

@@ rtl/sprq_store.sv @@
// ----------------------------------------------------------------------------
// sprq_store
// Entry memory: one write port, one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module sprq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sprq_cmp.sv @@
// ----------------------------------------------------------------------------
// sprq_cmp
// Shared compare unit: orders a stored entry against the working key by
// timestamp first, then by pid.
// ----------------------------------------------------------------------------
module sprq_cmp
    import sprq_pkg::*;
#(
    parameter int TS_BITS  = 16,
    parameter int PID_BITS = 8
) (
    input  logic [TS_BITS-1:0]  i_ent_ts,
    input  logic [PID_BITS-1:0] i_ent_pid,
    input  logic [TS_BITS-1:0]  i_key_ts,
    input  logic [PID_BITS-1:0] i_key_pid,
    output t_cmp                o_cmp
);

    always_comb begin
        if (i_ent_ts != i_key_ts) begin
            o_cmp.after = (i_ent_ts > i_key_ts);
        end else begin
            o_cmp.after = (i_ent_pid > i_key_pid);
        end
        o_cmp.equal = (i_ent_ts == i_key_ts) && (i_ent_pid == i_key_pid);
    end

endmodule

@@ rtl/sorted_request_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_request_priority_queue_top
// Sorted queue of (timestamp, pid) requests with insert, replace, pop-min
// and remove, walked one entry at a time through the entry memory.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries in ascending (timestamp, pid) order in
// a memory with one write and one registered read port; requests walk that
// memory under a small sequencer, visiting each entry with a read, then a
// compare and move. Pop-min and remove walk all entries held, insert walks
// from the tail toward the head until it meets an entry that sorts no later
// than the new one, and replace runs the remove walk followed by the insert
// steps. Insert into a full or an empty queue, replace on an empty queue, and
// pop-min or remove on an empty queue return without a walk. One request is
// in flight at a time; the ready output comes back in the same cycle that the
// response goes valid. The result sits in an output register so the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
module sorted_request_priority_queue_top
    import sprq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TS_BITS  = 16,
    parameter int PID_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic [1:0]          i_req_type,
    input  logic [TS_BITS-1:0]  i_key_timestamp,
    input  logic [PID_BITS-1:0] i_key_pid,
    input  logic [TS_BITS-1:0]  i_old_timestamp,

    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [1:0]          o_status,
    output logic [TS_BITS-1:0]  o_popped_timestamp,
    output logic [PID_BITS-1:0] o_popped_pid,
    output logic                o_head_valid,
    output logic [TS_BITS-1:0]  o_head_timestamp,
    output logic [PID_BITS-1:0] o_head_pid,
    output logic [4:0]          o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TS_BITS + PID_BITS;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INS_START = 8'b0000_0010,
        S_RM_RD     = 8'b0000_0100,
        S_RM_CHK    = 8'b0000_1000,
        S_INS_RD    = 8'b0001_0000,
        S_INS_CHK   = 8'b0010_0000,
        S_INS_LAST  = 8'b0100_0000,
        S_FIN       = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_idx, n_idx;
    t_req                 r_op, n_op;
    logic [TS_BITS-1:0]   r_key_ts, n_key_ts;
    logic [TS_BITS-1:0]   r_rm_ts, n_rm_ts;
    logic [PID_BITS-1:0]  r_key_pid, n_key_pid;
    logic                 r_found, n_found;
    logic                 r_miss, n_miss;
    t_status              r_status, n_status;
    logic [TS_BITS-1:0]   r_pop_ts, n_pop_ts;
    logic [PID_BITS-1:0]  r_pop_pid, n_pop_pid;
    logic [EW-1:0]        r_head;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [TS_BITS-1:0]   r_out_pop_ts, n_out_pop_ts;
    logic [PID_BITS-1:0]  r_out_pop_pid, n_out_pop_pid;
    logic                 r_out_hv, n_out_hv;
    logic [TS_BITS-1:0]   r_out_head_ts, n_out_head_ts;
    logic [PID_BITS-1:0]  r_out_head_pid, n_out_head_pid;
    logic [4:0]           r_out_cnt, n_out_cnt;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [EW-1:0]        w_wdata;
    logic [EW-1:0]        w_rdata;
    logic [TS_BITS-1:0]   w_ent_ts;
    logic [PID_BITS-1:0]  w_ent_pid;
    logic [TS_BITS-1:0]   w_cmp_ts;
    t_cmp                 w_cmp;
    logic [CW-1:0]        w_cnt_m1;
    logic                 w_last;
    logic                 w_match;
    logic                 w_found_now;
    logic                 w_req_acc;
    logic                 w_out_free;

    assign w_req_acc   = i_req_valid && o_req_ready;
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_ent_ts    = w_rdata[EW-1:PID_BITS];
    assign w_ent_pid   = w_rdata[PID_BITS-1:0];
    assign w_cnt_m1    = r_cnt - CW'(1);
    assign w_last      = (CW'(r_idx) == w_cnt_m1);
    assign w_cmp_ts    = (r_state == S_RM_CHK) ? r_rm_ts : r_key_ts;
    assign w_match     = (r_op == REQ_POP_MIN) ? (r_idx == '0) : w_cmp.equal;
    assign w_found_now = r_found || w_match;

    sprq_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    sprq_cmp #(
        .TS_BITS  (TS_BITS),
        .PID_BITS (PID_BITS)
    ) u_cmp (
        .i_ent_ts  (w_ent_ts),
        .i_ent_pid (w_ent_pid),
        .i_key_ts  (w_cmp_ts),
        .i_key_pid (r_key_pid),
        .o_cmp     (w_cmp)
    );

    // Memory write port: close the gap on remove, open a slot on insert and write the new entry.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {r_key_ts, r_key_pid};
        unique case (r_state)
            S_INS_START: begin
                w_we    = (r_cnt == '0);
                w_waddr = '0;
            end
            S_RM_CHK: begin
                w_we    = r_found;
                w_waddr = r_idx - AW'(1);
                w_wdata = w_rdata;
            end
            S_INS_CHK: begin
                w_we    = 1'b1;
                w_waddr = r_idx + AW'(1);
                w_wdata = w_cmp.after ? w_rdata : {r_key_ts, r_key_pid};
            end
            S_INS_LAST: begin
                w_we    = 1'b1;
                w_waddr = '0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_idx          = r_idx;
        n_op           = r_op;
        n_key_ts       = r_key_ts;
        n_rm_ts        = r_rm_ts;
        n_key_pid      = r_key_pid;
        n_found        = r_found;
        n_miss         = r_miss;
        n_status       = r_status;
        n_pop_ts       = r_pop_ts;
        n_pop_pid      = r_pop_pid;
        n_out_valid    = r_out_valid && !i_rsp_ready;
        n_out_status   = r_out_status;
        n_out_pop_ts   = r_out_pop_ts;
        n_out_pop_pid  = r_out_pop_pid;
        n_out_hv       = r_out_hv;
        n_out_head_ts  = r_out_head_ts;
        n_out_head_pid = r_out_head_pid;
        n_out_cnt      = r_out_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_op      = t_req'(i_req_type);
                    n_key_ts  = i_key_timestamp;
                    n_key_pid = i_key_pid;
                    n_rm_ts   = (t_req'(i_req_type) == REQ_REPLACE) ? i_old_timestamp
                                                                     : i_key_timestamp;
                    n_found   = 1'b0;
                    n_miss    = 1'b0;
                    n_status  = ST_OK;
                    n_pop_ts  = '0;
                    n_pop_pid = '0;
                    n_idx     = '0;
                    case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            n_state = S_INS_START;
                        end
                        REQ_REPLACE: begin
                            if (r_cnt == '0) begin
                                n_miss  = 1'b1;
                                n_state = S_INS_START;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                    endcase
                end
            end
            S_RM_RD: begin
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                if (!r_found && w_match) begin
                    n_found = 1'b1;
                    if (r_op == REQ_POP_MIN) begin
                        n_pop_ts  = w_ent_ts;
                        n_pop_pid = w_ent_pid;
                    end
                end
                if (w_last) begin
                    if (w_found_now) begin
                        n_cnt = w_cnt_m1;
                    end
                    if (r_op == REQ_REPLACE) begin
                        n_miss  = !w_found_now;
                        n_state = S_INS_START;
                    end else begin
                        n_status = w_found_now ? ST_OK : ST_MISSING;
                        n_state  = S_FIN;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_RM_RD;
                end
            end
            S_INS_START: begin
                if (r_cnt == CW'(DEPTH)) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else if (r_cnt == '0) begin
                    n_cnt    = r_cnt + CW'(1);
                    n_status = r_miss ? ST_MISSING : ST_OK;
                    n_state  = S_FIN;
                end else begin
                    n_idx   = AW'(w_cnt_m1);
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (w_cmp.after) begin
                    if (r_idx == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_cnt    = r_cnt + CW'(1);
                    n_status = r_miss ? ST_MISSING : ST_OK;
                    n_state  = S_FIN;
                end
            end
            S_INS_LAST: begin
                n_cnt    = r_cnt + CW'(1);
                n_status = r_miss ? ST_MISSING : ST_OK;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register is free, then load the beat.
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_status   = r_status;
                    n_out_pop_ts   = r_pop_ts;
                    n_out_pop_pid  = r_pop_pid;
                    n_out_hv       = (r_cnt != '0);
                    n_out_head_ts  = (r_cnt != '0) ? r_head[EW-1:PID_BITS] : '0;
                    n_out_head_pid = (r_cnt != '0) ? r_head[PID_BITS-1:0] : '0;
                    n_out_cnt      = 5'(r_cnt);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_op           <= n_op;
        r_key_ts       <= n_key_ts;
        r_rm_ts        <= n_rm_ts;
        r_key_pid      <= n_key_pid;
        r_found        <= n_found;
        r_miss         <= n_miss;
        r_status       <= n_status;
        r_pop_ts       <= n_pop_ts;
        r_pop_pid      <= n_pop_pid;
        r_out_status   <= n_out_status;
        r_out_pop_ts   <= n_out_pop_ts;
        r_out_pop_pid  <= n_out_pop_pid;
        r_out_hv       <= n_out_hv;
        r_out_head_ts  <= n_out_head_ts;
        r_out_head_pid <= n_out_head_pid;
        r_out_cnt      <= n_out_cnt;
    end

    // Mirror of entry zero: track every write to the head slot.
    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr == '0)) begin
            r_head <= w_wdata;
        end
    end

    assign o_req_ready        = (r_state == S_IDLE);
    assign o_rsp_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_popped_timestamp = r_out_pop_ts;
    assign o_popped_pid       = r_out_pop_pid;
    assign o_head_valid       = r_out_hv;
    assign o_head_timestamp   = r_out_head_ts;
    assign o_head_pid         = r_out_head_pid;
    assign o_entry_count      = r_out_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FIN) |-> !w_we)
        else $error("memory write outside a walk");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) && (o_status == ST_EMPTY) |-> !o_head_valid)
        else $error("empty status with a live head");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) && (o_status == ST_FULL) |-> o_head_valid)
        else $error("full status with no head");

endmodule
